// ===== hw/rtl/lcrc_pkg.sv =====
// Shared types and constants for the load cell report calibrator.
// No dependencies; used by load_cell_report_calibrator_core.
package lcrc_pkg;

    localparam int REPORT_BYTES_DEF = 23;

    localparam logic [7:0]  HDR_INPUT   = 8'hA1;
    localparam logic [7:0]  HDR_OUTPUT  = 8'hA2;
    localparam logic [7:0]  RPT_DATA    = 8'h34;
    localparam logic [7:0]  RPT_STATUS  = 8'h20;
    localparam logic [7:0]  RPT_READ    = 8'h21;
    localparam logic [7:0]  RPT_ACK     = 8'h22;
    localparam logic [7:0]  CMD_WRITE   = 8'h16;
    localparam logic [7:0]  CMD_READ    = 8'h17;
    localparam logic [7:0]  CMD_MODE    = 8'h12;
    localparam logic [7:0]  SPACE_REG   = 8'h04;
    localparam logic [7:0]  ENC_KEY     = 8'h55;

    localparam logic [23:0] ADDR_ENC0   = 24'hA400F0;
    localparam logic [23:0] ADDR_ENC1   = 24'hA400FB;
    localparam logic [23:0] ADDR_IDENT  = 24'hA400FA;
    localparam logic [23:0] ADDR_CAL0   = 24'hA40024;
    localparam logic [23:0] ADDR_CAL1   = 24'hA40034;
    localparam logic [23:0] ADDR_TEMP   = 24'hA40060;

    localparam logic [14:0] GRAM_SPAN   = 15'd17000;
    localparam logic [17:0] WEIGHT_MAX  = 18'h3FFFF;

    localparam logic [7:0] IDENT_BYTES [8] =
        '{8'h00, 8'hFA, 8'h00, 8'h00, 8'hA4, 8'h20, 8'h04, 8'h02};

    localparam int TDATA_W = 120;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FETCH,
        ST_F17,
        ST_F34,
        ST_BRANCH,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_WOUT,
        ST_CEMIT
    } state_t;

    typedef enum logic [1:0] {
        CK_WRITE,
        CK_READ,
        CK_MODE
    } cmd_kind_t;

endpackage

// ===== hw/rtl/load_cell_report_calibrator_core.sv =====
// Load cell report calibrator: report buffer, setup sequencer and weight unit.
// Depends on lcrc_pkg.
//
// Channel  Dir  Handshake                 Payload
// s_*      in   s_tvalid/s_tready         s_tdata=rx_byte, s_tlast=rx_last
// m_*      out  m_tvalid/m_tready         m_tdata=result fields, m_tlast=tx_last,
//                                         m_tuser=out_kind
// cfg_*    in   cfg_valid/cfg_ready       cfg_data=connection_handle
//
// A non-final byte is stored in the buffer. A final byte is decoded, then
// either a command of 4, 8 or 23 words is emitted, or, for a data report,
// each load cell goes through three table fetches, one branch, one multiply,
// a 31-step restoring divide and one store (the multiply and divide are
// skipped when no divide is needed), followed by one output word.
// Reset clears the buffer fill count, setup step, calibration table and
// reference temperature. A stall on m_* holds the sequencer before each word.
module load_cell_report_calibrator_core #(
    parameter int REPORT_BYTES = lcrc_pkg::REPORT_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] rx_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] tx_byte, [25:8] weight_tr, [43:26] weight_br, [61:44] weight_tl,
    // [79:62] weight_bl, [87:80] temperature, [95:88] battery,
    // [103:96] ref_temp_out, [115:104] link_id, [119:116] zero
    output logic [lcrc_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser,    // [0] out_kind
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [11:0]                 cfg_data    // [11:0] connection_handle
);

    localparam int CW = $clog2(REPORT_BYTES + 1);
    localparam int BW = $clog2(REPORT_BYTES);

    lcrc_pkg::state_t    state_reg, state_next;
    lcrc_pkg::cmd_kind_t kind_reg, kind_next;

    logic [7:0]  buf_reg [REPORT_BYTES];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]  rbv [REPORT_BYTES];
    logic [2:0]  step_reg, step_next;
    logic [15:0] cal_reg [12];
    logic [15:0] cal_next [12];
    logic [7:0]  reft_reg, reft_next;
    logic [11:0] link_reg;

    logic [23:0] addr_reg, addr_next;
    logic [7:0]  arg_reg, arg_next;
    logic [4:0]  k_reg, k_next;
    logic [4:0]  n_last;

    logic [1:0]  ch_reg, ch_next;
    logic [15:0] v_reg, v_next, c0_reg, c0_next, c17_reg, c17_next, c34_reg, c34_next;
    logic [15:0] diff_reg, diff_next, den_reg, den_next;
    logic [14:0] base_reg, base_next;
    logic [16:0] rem_reg, rem_next;
    logic [30:0] quo_reg, quo_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [17:0] wgt_reg [4];
    logic [17:0] wgt_next [4];

    logic        out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic        out_kind_reg, out_kind_next;
    logic [lcrc_pkg::TDATA_W-1:0] out_data_reg, out_data_next;

    logic        in_acc, out_free, ident_ok;
    logic [7:0]  rtype;
    logic [15:0] word_v, cal_rd;
    logic [3:0]  cal_idx;
    logic [30:0] prod;
    logic [16:0] rem_sh;
    logic [31:0] wsum;
    logic [7:0]  cmd_b;

    assign s_tready  = (state_reg == lcrc_pkg::ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_kind_reg;

    // Bytes beyond the fill count were not received this report and read as zero.
    always_comb
    begin
        for (int i = 0; i < REPORT_BYTES; i++)
        begin
            rbv[i] = (CW'(i) < cnt_reg) ? buf_reg[i] : 8'h00;
        end
    end

    assign rtype = rbv[1];

    always_comb
    begin
        ident_ok = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (rbv[5 + i] != lcrc_pkg::IDENT_BYTES[i])
            begin
                ident_ok = 1'b0;
            end
        end
    end

    // Count word for the current channel, big-endian at byte 4 + 2*ch.
    always_comb
    begin
        case (ch_reg)
            2'd0:    word_v = {rbv[4],  rbv[5]};
            2'd1:    word_v = {rbv[6],  rbv[7]};
            2'd2:    word_v = {rbv[8],  rbv[9]};
            default: word_v = {rbv[10], rbv[11]};
        endcase
    end

    // One calibration read port; the fetch state selects the row.
    always_comb
    begin
        case (state_reg)
            lcrc_pkg::ST_F17: cal_idx = {2'b01, ch_reg};
            lcrc_pkg::ST_F34: cal_idx = {2'b10, ch_reg};
            default:          cal_idx = {2'b00, ch_reg};
        endcase
        cal_rd = (cal_idx < 4'd12) ? cal_reg[cal_idx] : 16'h0000;
    end

    assign prod   = 31'(lcrc_pkg::GRAM_SPAN) * 31'(diff_reg);
    assign rem_sh = {rem_reg[15:0], quo_reg[30]};
    assign wsum   = 32'(base_reg) + 32'(quo_reg);

    // Command word bytes by position.
    always_comb
    begin
        cmd_b = 8'h00;
        case (kind_reg)
            lcrc_pkg::CK_WRITE:
            begin
                n_last = 5'd22;
                case (k_reg)
                    5'd0:    cmd_b = lcrc_pkg::HDR_OUTPUT;
                    5'd1:    cmd_b = lcrc_pkg::CMD_WRITE;
                    5'd2:    cmd_b = lcrc_pkg::SPACE_REG;
                    5'd3:    cmd_b = addr_reg[23:16];
                    5'd4:    cmd_b = addr_reg[15:8];
                    5'd5:    cmd_b = addr_reg[7:0];
                    5'd6:    cmd_b = 8'h01;
                    5'd7:    cmd_b = arg_reg;
                    default: cmd_b = 8'h00;
                endcase
            end
            lcrc_pkg::CK_READ:
            begin
                n_last = 5'd7;
                case (k_reg)
                    5'd0:    cmd_b = lcrc_pkg::HDR_OUTPUT;
                    5'd1:    cmd_b = lcrc_pkg::CMD_READ;
                    5'd2:    cmd_b = lcrc_pkg::SPACE_REG;
                    5'd3:    cmd_b = addr_reg[23:16];
                    5'd4:    cmd_b = addr_reg[15:8];
                    5'd5:    cmd_b = addr_reg[7:0];
                    5'd6:    cmd_b = 8'h00;
                    default: cmd_b = arg_reg;
                endcase
            end
            default:
            begin
                n_last = 5'd3;
                case (k_reg)
                    5'd0:    cmd_b = lcrc_pkg::HDR_OUTPUT;
                    5'd1:    cmd_b = lcrc_pkg::CMD_MODE;
                    5'd2:    cmd_b = 8'h00;
                    default: cmd_b = lcrc_pkg::RPT_DATA;
                endcase
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcrc_pkg::ST_IDLE:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = lcrc_pkg::ST_DECIDE;
                end
            end
            lcrc_pkg::ST_DECIDE:
            begin
                state_next = lcrc_pkg::ST_IDLE;
                if (rbv[0] == lcrc_pkg::HDR_INPUT)
                begin
                    if (rtype == lcrc_pkg::RPT_DATA && reft_reg != 8'h00)
                    begin
                        state_next = lcrc_pkg::ST_FETCH;
                    end
                    else
                    begin
                        case (step_reg)
                            3'd0:
                            begin
                                if (rtype == lcrc_pkg::RPT_STATUS && rbv[4][1])
                                begin
                                    state_next = lcrc_pkg::ST_CEMIT;
                                end
                            end
                            3'd1, 3'd2:
                            begin
                                if (rtype == lcrc_pkg::RPT_ACK && rbv[4] == lcrc_pkg::CMD_WRITE
                                    && rbv[5] == 8'h00)
                                begin
                                    state_next = lcrc_pkg::ST_CEMIT;
                                end
                            end
                            3'd3:
                            begin
                                if (rtype == lcrc_pkg::RPT_READ && ident_ok)
                                begin
                                    state_next = lcrc_pkg::ST_CEMIT;
                                end
                            end
                            3'd4, 3'd5, 3'd6: state_next = lcrc_pkg::ST_CEMIT;
                            default:          state_next = lcrc_pkg::ST_IDLE;
                        endcase
                    end
                end
            end
            lcrc_pkg::ST_FETCH:  state_next = lcrc_pkg::ST_F17;
            lcrc_pkg::ST_F17:    state_next = lcrc_pkg::ST_F34;
            lcrc_pkg::ST_F34:    state_next = lcrc_pkg::ST_BRANCH;
            lcrc_pkg::ST_BRANCH:
            begin
                if (v_reg < c0_reg || (v_reg >= c17_reg && c34_reg <= c17_reg))
                begin
                    state_next = lcrc_pkg::ST_STORE;
                end
                else
                begin
                    state_next = lcrc_pkg::ST_MUL;
                end
            end
            lcrc_pkg::ST_MUL:    state_next = lcrc_pkg::ST_DIV;
            lcrc_pkg::ST_DIV:
            begin
                if (dcnt_reg == 5'd30)
                begin
                    state_next = lcrc_pkg::ST_STORE;
                end
            end
            lcrc_pkg::ST_STORE:
            begin
                state_next = (ch_reg == 2'd3) ? lcrc_pkg::ST_WOUT : lcrc_pkg::ST_FETCH;
            end
            lcrc_pkg::ST_WOUT:
            begin
                if (out_free)
                begin
                    state_next = lcrc_pkg::ST_IDLE;
                end
            end
            lcrc_pkg::ST_CEMIT:
            begin
                if (out_free && k_reg == n_last)
                begin
                    state_next = lcrc_pkg::ST_IDLE;
                end
            end
            default: state_next = lcrc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        cnt_next  = cnt_reg;
        step_next = step_reg;
        cal_next  = cal_reg;
        reft_next = reft_reg;
        kind_next = kind_reg;
        addr_next = addr_reg;
        arg_next  = arg_reg;
        k_next    = k_reg;
        ch_next   = ch_reg;
        v_next    = v_reg;
        c0_next   = c0_reg;
        c17_next  = c17_reg;
        c34_next  = c34_reg;
        diff_next = diff_reg;
        den_next  = den_reg;
        base_next = base_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        wgt_next  = wgt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;

        if (in_acc && cnt_reg < CW'(REPORT_BYTES))
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        case (state_reg)
            lcrc_pkg::ST_DECIDE:
            begin
                ch_next = 2'd0;
                k_next  = 5'd0;
                if (rbv[0] == lcrc_pkg::HDR_INPUT
                    && !(rtype == lcrc_pkg::RPT_DATA && reft_reg != 8'h00))
                begin
                    case (step_reg)
                        3'd0:
                        begin
                            if (rtype == lcrc_pkg::RPT_STATUS && rbv[4][1])
                            begin
                                step_next = 3'd1;
                                kind_next = lcrc_pkg::CK_WRITE;
                                addr_next = lcrc_pkg::ADDR_ENC0;
                                arg_next  = lcrc_pkg::ENC_KEY;
                            end
                        end
                        3'd1, 3'd2:
                        begin
                            if (rtype == lcrc_pkg::RPT_ACK && rbv[4] == lcrc_pkg::CMD_WRITE)
                            begin
                                if (rbv[5] != 8'h00)
                                begin
                                    step_next = 3'd0;
                                end
                                else if (step_reg == 3'd1)
                                begin
                                    step_next = 3'd2;
                                    kind_next = lcrc_pkg::CK_WRITE;
                                    addr_next = lcrc_pkg::ADDR_ENC1;
                                    arg_next  = 8'h00;
                                end
                                else
                                begin
                                    step_next = 3'd3;
                                    kind_next = lcrc_pkg::CK_READ;
                                    addr_next = lcrc_pkg::ADDR_IDENT;
                                    arg_next  = 8'd6;
                                end
                            end
                        end
                        3'd3:
                        begin
                            if (rtype == lcrc_pkg::RPT_READ)
                            begin
                                if (ident_ok)
                                begin
                                    step_next = 3'd4;
                                    kind_next = lcrc_pkg::CK_READ;
                                    addr_next = lcrc_pkg::ADDR_CAL0;
                                    arg_next  = 8'd16;
                                end
                                else
                                begin
                                    step_next = 3'd0;
                                end
                            end
                        end
                        3'd4:
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                cal_next[i] = {rbv[7 + 2 * i], rbv[8 + 2 * i]};
                            end
                            step_next = 3'd5;
                            kind_next = lcrc_pkg::CK_READ;
                            addr_next = lcrc_pkg::ADDR_CAL1;
                            arg_next  = 8'd8;
                        end
                        3'd5:
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                cal_next[8 + i] = {rbv[7 + 2 * i], rbv[8 + 2 * i]};
                            end
                            step_next = 3'd6;
                            kind_next = lcrc_pkg::CK_READ;
                            addr_next = lcrc_pkg::ADDR_TEMP;
                            arg_next  = 8'd2;
                        end
                        3'd6:
                        begin
                            reft_next = rbv[7];
                            step_next = 3'd0;
                            kind_next = lcrc_pkg::CK_MODE;
                        end
                        default: step_next = 3'd0;
                    endcase
                end
            end
            lcrc_pkg::ST_FETCH:
            begin
                v_next  = word_v;
                c0_next = cal_rd;
            end
            lcrc_pkg::ST_F17: c17_next = cal_rd;
            lcrc_pkg::ST_F34: c34_next = cal_rd;
            lcrc_pkg::ST_BRANCH:
            begin
                quo_next  = 31'd0;
                base_next = 15'd0;
                if (v_reg < c0_reg)
                begin
                    base_next = 15'd0;
                end
                else if (v_reg < c17_reg)
                begin
                    diff_next = v_reg - c0_reg;
                    den_next  = c17_reg - c0_reg;
                end
                else
                begin
                    base_next = lcrc_pkg::GRAM_SPAN;
                    diff_next = v_reg - c17_reg;
                    den_next  = c34_reg - c17_reg;
                end
            end
            lcrc_pkg::ST_MUL:
            begin
                quo_next  = prod;
                rem_next  = 17'd0;
                dcnt_next = 5'd0;
            end
            lcrc_pkg::ST_DIV:
            begin
                // One restoring divide step per cycle.
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    quo_next = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[29:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
            end
            lcrc_pkg::ST_STORE:
            begin
                wgt_next[ch_reg] = (wsum > 32'(lcrc_pkg::WEIGHT_MAX))
                                   ? lcrc_pkg::WEIGHT_MAX : wsum[17:0];
                ch_next = ch_reg + 1'b1;
            end
            lcrc_pkg::ST_WOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_kind_next  = 1'b0;
                    out_data_next  = {4'h0, link_reg, reft_reg, rbv[14], rbv[12],
                                      wgt_reg[3], wgt_reg[2], wgt_reg[1], wgt_reg[0], 8'h00};
                end
            end
            lcrc_pkg::ST_CEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = (k_reg == n_last);
                    out_kind_next  = 1'b1;
                    out_data_next  = {4'h0, link_reg, 96'h0, cmd_b};
                    k_next         = k_reg + 1'b1;
                end
            end
            default: ;
        endcase

        // Clear the buffer fill count at the end of every report.
        if (state_reg != lcrc_pkg::ST_IDLE && state_next == lcrc_pkg::ST_IDLE)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcrc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= 3'd0;
            reft_reg      <= 8'h00;
            link_reg      <= 12'h000;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 12; i++)
            begin
                cal_reg[i] <= 16'h0000;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            reft_reg      <= reft_next;
            out_valid_reg <= out_valid_next;
            cal_reg       <= cal_next;
            if (cfg_valid && cfg_ready)
            begin
                link_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && cnt_reg < CW'(REPORT_BYTES))
        begin
            buf_reg[cnt_reg[BW-1:0]] <= s_tdata;
        end
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        arg_reg      <= arg_next;
        k_reg        <= k_next;
        ch_reg       <= ch_next;
        v_reg        <= v_next;
        c0_reg       <= c0_next;
        c17_reg      <= c17_next;
        c34_reg      <= c34_next;
        diff_reg     <= diff_next;
        den_reg      <= den_next;
        base_reg     <= base_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        wgt_reg      <= wgt_next;
        out_last_reg <= out_last_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

endmodule
